### hdl/hlpd_pkg.sv
`timescale 1ns / 1ps

package hlpd_pkg;

   // header size in bytes: command byte plus four hex digits
   localparam int unsigned HEADER_BYTES = 5;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
   localparam logic [1:0] KIND_EMPTY     = 2'd1;
   localparam logic [1:0] KIND_BAD_HEX   = 2'd2;
   localparam logic [1:0] KIND_TOO_LARGE = 2'd3;

   // buffer_size reset value
   localparam logic [17:0] BUFFER_SIZE_RESET = 18'd4096;

   // one result record, as carried from the parser to the result queue
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  command;
      logic [7:0]  data;
      logic [15:0] frame_length;
      logic        last;
   } result_type;

   // parser-to-queue write beat
   typedef struct packed {
      logic       valid;
      result_type result;
   } result_beat_type;

endpackage

### hdl/hlpd_parser.sv
`timescale 1ns / 1ps

module hlpd_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               byte_in,
   input  logic [17:0]              buffer_size,
   output hlpd_pkg::result_beat_type beat_out
);

   typedef enum logic [2:0] {
      PH_CMD = 3'b001,
      PH_HDR = 3'b010,
      PH_PAY = 3'b100
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  digit_count_ff, digit_count_in;
   logic [7:0]  held_command_ff, held_command_in;
   logic [15:0] length_accum_ff, length_accum_in;
   logic [15:0] bytes_left_ff, bytes_left_in;

   // decode one ASCII hex digit: bit 4 set means not a hex digit
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b10000;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
      return r;
   endfunction

   logic [4:0]  hex;
   logic [15:0] new_length;
   logic [16:0] length_sum;
   logic        too_large;
   logic [15:0] left_dec;

   assign hex        = hex_decode(byte_in);
   assign new_length = {length_accum_ff[11:0], hex[3:0]};
   assign length_sum = {1'b0, new_length} + 17'(hlpd_pkg::HEADER_BYTES);
   assign too_large  = {1'b0, length_sum} >= buffer_size;
   assign left_dec   = (bytes_left_ff != 16'd0) ? bytes_left_ff - 16'd1 : 16'd0;

   // classify the byte and compute next parser state
   always_comb begin
      phase_in        = phase_ff;
      digit_count_in  = digit_count_ff;
      held_command_in = held_command_ff;
      length_accum_in = length_accum_ff;
      bytes_left_in   = bytes_left_ff;
      beat_out.valid               = 1'b0;
      beat_out.result.kind         = hlpd_pkg::KIND_PAYLOAD;
      beat_out.result.command      = held_command_ff;
      beat_out.result.data         = 8'd0;
      beat_out.result.frame_length = 16'd0;
      beat_out.result.last         = 1'b1;
      case (phase_ff)
         PH_HDR: begin
            if (hex[4]) begin
               beat_out.valid       = accept;
               beat_out.result.kind = hlpd_pkg::KIND_BAD_HEX;
               phase_in             = PH_CMD;
               digit_count_in       = 2'd0;
            end else begin
               length_accum_in = new_length;
               if (digit_count_ff != 2'd3) begin
                  digit_count_in = digit_count_ff + 2'd1;
               end else begin
                  digit_count_in = 2'd0;
                  if (too_large) begin
                     beat_out.valid               = accept;
                     beat_out.result.kind         = hlpd_pkg::KIND_TOO_LARGE;
                     beat_out.result.frame_length = new_length;
                     phase_in                     = PH_CMD;
                  end else if (new_length == 16'd0) begin
                     beat_out.valid       = accept;
                     beat_out.result.kind = hlpd_pkg::KIND_EMPTY;
                     phase_in             = PH_CMD;
                  end else begin
                     bytes_left_in = new_length;
                     phase_in      = PH_PAY;
                  end
               end
            end
         end
         PH_PAY: begin
            bytes_left_in                = left_dec;
            beat_out.valid               = accept;
            beat_out.result.kind         = hlpd_pkg::KIND_PAYLOAD;
            beat_out.result.data         = byte_in;
            beat_out.result.frame_length = length_accum_ff;
            beat_out.result.last         = (left_dec == 16'd0);
            if (left_dec == 16'd0) phase_in = PH_CMD;
         end
         default: begin
            held_command_in = byte_in;
            length_accum_in = 16'd0;
            digit_count_in  = 2'd0;
            bytes_left_in   = 16'd0;
            phase_in        = PH_HDR;
         end
      endcase
   end

   // advance state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_CMD;
         digit_count_ff  <= 2'd0;
         held_command_ff <= 8'd0;
         length_accum_ff <= 16'd0;
         bytes_left_ff   <= 16'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         digit_count_ff  <= digit_count_in;
         held_command_ff <= held_command_in;
         length_accum_ff <= length_accum_in;
         bytes_left_ff   <= bytes_left_in;
      end
   end

endmodule

### hdl/hlpd_queue.sv
`timescale 1ns / 1ps

module hlpd_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  hlpd_pkg::result_beat_type beat_in,
   output logic                      full,
   output logic                      empty,
   input  logic                      pop,
   output hlpd_pkg::result_type      head
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   hlpd_pkg::result_type entries_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = beat_in.valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   // wrap pointers and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed record
   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= beat_in.result;
   end

endmodule

### hdl/hex_length_prefixed_deframer_top.sv
`timescale 1ns / 1ps
// A result is registered into the result queue when the byte causing it is accepted and
// shows on rsp_ ports at the queue head. One byte per cycle while req_full is low: the
// parser decodes, compares or counts down each byte and the queue takes and gives one
// record per cycle. req_full rises only while the result queue holds QUEUE_DEPTH records.
// Reset (synchronous): parser waits for a command byte, queue empties, buffer_size = 4096.

module hex_length_prefixed_deframer_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_command,
   output logic [7:0]  rsp_data,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [17:0] csr_buffer_size
);

   logic [17:0]               buffer_size_ff;
   logic                      accept;
   hlpd_pkg::result_beat_type beat;
   hlpd_pkg::result_type      head;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   // hold the buffer size register
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= hlpd_pkg::BUFFER_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         buffer_size_ff <= csr_buffer_size;
      end
   end

   // front: parse and classify bytes
   hlpd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .byte_in     (req_byte_in),
      .buffer_size (buffer_size_ff),
      .beat_out    (beat)
   );

   // back: queue results toward the consumer
   hlpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .beat_in (beat),
      .full    (req_full),
      .empty   (rsp_empty),
      .pop     (rsp_pop),
      .head    (head)
   );

   assign rsp_kind         = head.kind;
   assign rsp_command      = head.command;
   assign rsp_data         = head.data;
   assign rsp_frame_length = head.frame_length;
   assign rsp_last         = head.last;

   // checks
   a_reset_empties: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("queue not empty after reset");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !beat.valid)
      else $error("parser produced a result while queue full");

   a_result_shows: assert property (@(posedge clock) disable iff (reset)
      (beat.valid && !(rsp_pop && !rsp_empty)) |=> !rsp_empty)
      else $error("pushed result not visible");

   a_nonpayload_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != hlpd_pkg::KIND_PAYLOAD) |-> (rsp_last && rsp_data == 8'd0))
      else $error("non-payload result without last or with data");

endmodule
